@@ rtl/kfq_pkg.sv @@
package kfq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_TAKE   = 3'd3,
    CMD_REKEY  = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

@@ rtl/keyed_fifo_queue_core.sv @@
// keyed_fifo_queue_core: ordered queue of keyed entries held in two
// synchronous memories (keys, payloads), each with one write port and one
// read port with a registered read.
//
// Channels: one command item in on s_axis (tdata = command, search_key,
// replacement_key, payload_in), one result item out on m_axis (tdata =
// status, payload_out, occupancy). Commands are processed one at a time.
//
// Push, clear, unknown commands and any command on an empty queue go
// straight to the done state. Lookup and rekey walk the key memory from
// the oldest entry, one entry per cycle, until a hit or the newest entry.
// Pop and take then copy every later entry down one slot, one slot per
// cycle. The one read port of each memory sets this pace.
//
// Reset clears the count and the control state; memory contents are left
// as they are, and entries beyond the count never reach a result.
// A stalled receiver holds the result in the output register; the next
// command is taken in the cycle after the result is accepted at the earliest.
module keyed_fifo_queue_core
  import kfq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] command, [34:3] search_key, [66:35] replacement_key,
  // [130:67] payload_in, [135:131] zero
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [65:2] payload_out, [72:66] occupancy, [79:73] zero
  output logic [79:0]  m_axis_tdata
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]           key_mem [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [QUEUE_DEPTH];
  logic [31:0]           key_rd;
  logic [PAYLOAD_BITS-1:0] pay_rd;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW:0]   idx;       // current read slot, runs up to count + 2
  logic          rd_ok;     // read issued last cycle for slot idx-1
  logic [2:0]    cmd;
  logic [31:0]   skey, rkey;
  logic [1:0]    res_status;
  logic [PAYLOAD_BITS-1:0] res_pay;
  logic          out_valid;

  // memory control
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wkey;
  logic [PAYLOAD_BITS-1:0] wpay;
  logic          wkey_only;

  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, 7'(count), 64'(res_pay), res_status};

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      if (!wkey_only) pay_mem[waddr] <= wpay;
    end
    key_rd <= key_mem[raddr];
    pay_rd <= pay_mem[raddr];
  end

  logic [CW:0] prev;
  assign prev  = idx - 1'b1;
  assign raddr = idx[AW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_axis_tvalid && s_axis_tready) begin
        case (cmd_t'(s_axis_tdata[2:0]))
          CMD_POP, CMD_LOOKUP, CMD_TAKE, CMD_REKEY:
            state_next = (count == '0) ? S_DONE : S_SCAN;
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN: if (rd_ok) begin
        if (cmd == CMD_POP || key_rd == skey)
          state_next = (cmd == CMD_POP || cmd == CMD_TAKE) ? S_SHIFT : S_DONE;
        else if (idx >= count) state_next = S_DONE;
      end
      S_SHIFT: if (rd_ok && idx >= count) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = prev[AW-1:0]; wkey = key_rd; wpay = pay_rd;
    wkey_only = 1'b0;
    case (state)
      S_IDLE: if (s_axis_tvalid && s_axis_tready &&
                  cmd_t'(s_axis_tdata[2:0]) == CMD_PUSH && count < CW'(QUEUE_DEPTH)) begin
        we = 1'b1; waddr = count[AW-1:0];
        wkey = s_axis_tdata[34:3]; wpay = PAYLOAD_BITS'(s_axis_tdata[130:67]);
      end
      S_SCAN: if (rd_ok && cmd == CMD_REKEY && key_rd == skey) begin
        we = 1'b1; wkey = rkey; wkey_only = 1'b1;
      end
      S_SHIFT: if (rd_ok) begin
        we = 1'b1; waddr = AW'(prev - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; idx <= '0; rd_ok <= 1'b0; out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cmd <= s_axis_tdata[2:0]; skey <= s_axis_tdata[34:3];
          rkey <= s_axis_tdata[66:35];
          res_status <= ST_OK; res_pay <= '0;
          idx <= '0; rd_ok <= 1'b0;
          case (cmd_t'(s_axis_tdata[2:0]))
            CMD_PUSH: if (count < CW'(QUEUE_DEPTH)) count <= count + 1'b1;
                      else res_status <= ST_FULL;
            CMD_CLEAR: begin
              if (count == '0) res_status <= ST_MISS;
              count <= '0;
            end
            CMD_POP, CMD_LOOKUP, CMD_TAKE, CMD_REKEY:
              if (count == '0) res_status <= ST_MISS;
            default: ;
          endcase
        end
        S_SCAN: begin
          if (rd_ok && (cmd == CMD_POP || key_rd == skey)) begin
            res_pay <= pay_rd;
            idx <= idx + 1'b1; rd_ok <= 1'b1;
          end else if (rd_ok && idx >= count) begin
            res_status <= ST_MISS;
          end else begin
            idx <= idx + 1'b1; rd_ok <= 1'b1;
          end
        end
        S_SHIFT: begin
          if (rd_ok && idx >= count) count <= count - 1'b1;
          else if (idx >= count) begin
            count <= count - 1'b1;
          end
          idx <= idx + 1'b1;
          rd_ok <= (idx < count);
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/kfq_checker.sv @@
module kfq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [79:0]  m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_st: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[65:2] == '0)
    else $error("payload not zero on miss");
endmodule

bind keyed_fifo_queue_core kfq_checker u_kfq_checker (.*);

@@ tb/tb_keyed_fifo_queue_core.sv @@
module tb_keyed_fifo_queue_core;
  timeunit 1ns;
  timeprecision 1ps;
  import kfq_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  // Same bit order as the result tdata: status lowest.
  typedef struct packed {
    logic [6:0]  occupancy;
    logic [63:0] payload;
    logic [1:0]  status;
  } result_t;

  // Queue predictor plus the list of results still owed by the block.
  class queue_scoreboard;
    logic [31:0] keys[$];
    logic [63:0] payloads[$];
    result_t     pending[$];
    int          errors;

    function void note_command(logic [2:0] cmd, logic [31:0] skey,
                               logic [31:0] rkey, logic [63:0] pin);
      result_t r;
      int pos;
      r = '0;
      r.status = ST_OK;
      pos = -1;
      case (cmd)
        CMD_PUSH: begin
          if (keys.size() >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            keys.push_back(skey);
            payloads.push_back(pin);
          end
        end
        CMD_POP: begin
          if (keys.size() == 0) begin
            r.status = ST_MISS;
          end else begin
            r.payload = payloads.pop_front();
            void'(keys.pop_front());
          end
        end
        CMD_LOOKUP, CMD_TAKE, CMD_REKEY: begin
          for (int i = 0; i < keys.size(); i++) begin
            if (pos < 0 && keys[i] == skey) pos = i;
          end
          if (pos < 0) begin
            r.status = ST_MISS;
          end else begin
            r.payload = payloads[pos];
            if (cmd == CMD_TAKE) begin
              keys.delete(pos);
              payloads.delete(pos);
            end else if (cmd == CMD_REKEY) begin
              keys[pos] = rkey;
            end
          end
        end
        CMD_CLEAR: begin
          if (keys.size() == 0) r.status = ST_MISS;
          keys.delete();
          payloads.delete();
        end
        default: ;
      endcase
      r.occupancy = 7'(keys.size());
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $error("result item with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.payload !== exp.payload) begin
        $error("payload_out: expected %h actual %h", exp.payload, got.payload);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d actual %0d", exp.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [2:0] command, [34:3] search_key, [66:35] replacement_key,
  // [130:67] payload_in, [135:131] zero
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [1:0] status, [65:2] payload_out, [72:66] occupancy, [79:73] zero
  logic [79:0]  m_axis_tdata;

  queue_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 1'b0;   // long hold-off to back the block up
  bit  stim_done = 1'b0;
  int  quiet_cycles = 0;

  // Small key pool so searches hit often and duplicates appear.
  logic [31:0] key_pool[8] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h1, 32'h5A5A_A5A5, 32'h2, 32'h3};

  keyed_fifo_queue_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one command; returns once it is accepted. Input is noted at accept.
  // tvalid stays high after the accept so the next item can follow directly.
  task automatic send_cmd(logic [2:0] cmd, logic [31:0] skey, logic [31:0] rkey,
                          logic [63:0] pin);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pin, rkey, skey, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_command(cmd, skey, rkey, pin);
  endtask

  task automatic send_random(bit well_formed);
    logic [2:0]  cmd;
    logic [31:0] skey, rkey;
    logic [63:0] pin;
    int pick;
    pick = $urandom_range(99);
    if (!well_formed)        cmd = 3'($urandom_range(7));
    else if (pick < 40)      cmd = CMD_PUSH;
    else if (pick < 55)      cmd = CMD_POP;
    else if (pick < 70)      cmd = CMD_LOOKUP;
    else if (pick < 85)      cmd = CMD_TAKE;
    else if (pick < 98)      cmd = CMD_REKEY;
    else                     cmd = CMD_CLEAR;
    skey = $urandom_range(3) == 0 ? $urandom() : key_pool[$urandom_range(7)];
    rkey = $urandom_range(1) == 0 ? $urandom() : key_pool[$urandom_range(7)];
    pin  = {$urandom(), $urandom()};
    send_cmd(cmd, skey, rkey, pin);
  endtask

  // Receiver: random stall, plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !recv_hold &&
                       !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Results are sampled at the edge where the handshake completes.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[72:0]);
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (stim_done && sb.pending.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-queue misses, extremes, duplicate keys, unknown codes.
    send_cmd(CMD_POP, 0, 0, 0);
    send_cmd(CMD_LOOKUP, 0, 0, 0);
    send_cmd(CMD_TAKE, 32'hFFFF_FFFF, 0, 0);
    send_cmd(CMD_REKEY, 0, 1, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0);
    send_cmd(CMD_PUSH, 32'h8000_0000, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_PUSH, 32'h7FFF_FFFF, 0, 64'h0);
    send_cmd(CMD_PUSH, 32'h8000_0000, 0, 64'h1234_5678_9ABC_DEF0);
    send_cmd(CMD_LOOKUP, 32'h8000_0000, 0, 0);
    send_cmd(CMD_REKEY, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_cmd(CMD_TAKE, 32'h7FFF_FFFF, 0, 0);
    send_cmd(CMD_LOOKUP, 32'h1, 0, 0);
    send_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(3'd7, 0, 0, 0);
    send_cmd(CMD_POP, 0, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0);
    // Fill to full and push once more.
    for (int i = 0; i <= DEPTH; i++) send_cmd(CMD_PUSH, i, 0, {$urandom(), $urandom()});
    send_cmd(CMD_TAKE, DEPTH - 1, 0, 0);
    send_cmd(CMD_POP, 0, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0);

    // Random phases: none, sender idle, receiver stalling, both light.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 0) begin
        // Back-pressure: block fills its output and stalls input.
        fork
          begin
            recv_hold = 1'b1;
            repeat (300) @(posedge clk);
            recv_hold = 1'b0;
          end
          repeat (20) send_random(1'b1);
        join
      end
      repeat (365) send_random($urandom_range(9) != 0);
    end
    s_axis_tvalid <= 1'b0;

    stim_done = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
